[hw/rtl/ssw_pkg.sv]
// Shared types, register map and reset values for the sliding surface wheel relay.
package ssw_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned LEVEL_W = 15;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned Q_FRAC  = 12;
    // rate error * 2^12 plus gain * yaw error, with headroom
    localparam int unsigned SURF_W  = 33;

    localparam logic [LEVEL_W-1:0] RST_SURFACE_GAIN     = 15'd3277;
    localparam logic [LEVEL_W-1:0] RST_SURFACE_ON       = 15'd82;
    localparam logic [LEVEL_W-1:0] RST_SURFACE_OFF      = 15'd16;
    localparam logic [LEVEL_W-1:0] RST_ERROR_ON         = 15'd1843;
    localparam logic [LEVEL_W-1:0] RST_ERROR_OFF        = 15'd819;
    localparam logic [LEVEL_W-1:0] RST_RATE_LIMIT       = 15'd1434;
    localparam logic [LEVEL_W-1:0] RST_RATE_ERROR_OFF   = 15'd20;

    localparam logic signed [1:0] DIR_POS  = 2'sb01;
    localparam logic signed [1:0] DIR_OFF  = 2'sb00;
    localparam logic signed [1:0] DIR_NEG  = 2'sb11;

    typedef enum logic [2:0] {
        REG_CONTROL_ENABLE   = 3'd0,
        REG_SURFACE_GAIN     = 3'd1,
        REG_SURFACE_ON       = 3'd2,
        REG_SURFACE_OFF      = 3'd3,
        REG_ERROR_ON         = 3'd4,
        REG_ERROR_OFF        = 3'd5,
        REG_RATE_LIMIT       = 3'd6,
        REG_RATE_ERROR_OFF   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic               control_enable;
        logic [LEVEL_W-1:0] surface_gain;
        logic [LEVEL_W-1:0] surface_on_level;
        logic [LEVEL_W-1:0] surface_off_level;
        logic [LEVEL_W-1:0] error_on_level;
        logic [LEVEL_W-1:0] error_off_level;
        logic [LEVEL_W-1:0] rate_limit;
        logic [LEVEL_W-1:0] rate_error_off_level;
    } cfg_t;

endpackage

[hw/rtl/sliding_surface_wheel_relay.sv]
// Top level of the sliding surface wheel relay: input stage, direction state, result stage.
//
// Usage:
//   Input channel (item_valid / item_stall) carries one control tick:
//   yaw_err, measured_rate, wanted_rate (signed Q3.12) and ready_req.
//   Result channel (result_valid / result_stall) carries wheel_dir, the
//   updated wheel command (+1, 0, -1) for that tick, one result per item.
//   Throughput is one item per cycle unless the receiver stalls. The item
//   register feeds one 16x16 multiply and a set of compares that land in the
//   result register, with the direction state updated as the item moves
//   across. When the receiver stalls, the result holds and the item register
//   keeps one further item; item_stall rises only when both are full. Reset
//   clears both stages, sets the direction to off and loads the register
//   defaults. Configuration goes through the APB-style port (registers at
//   4*index, pready always high); the user configures only while no item is
//   in flight, which the block itself does not enforce.
module sliding_surface_wheel_relay (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssw_pkg::ADDR_W-1:0]          paddr,
    input  logic [ssw_pkg::PDATA_W-1:0]         pwdata,
    output logic [ssw_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic signed [ssw_pkg::DATA_W-1:0]   yaw_err,
    input  logic signed [ssw_pkg::DATA_W-1:0]   measured_rate,
    input  logic signed [ssw_pkg::DATA_W-1:0]   wanted_rate,
    input  logic                                ready_req,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [1:0]                   wheel_dir
);

    ssw_pkg::cfg_t cfg;

    logic                              in_valid_reg;
    logic signed [ssw_pkg::DATA_W-1:0] yaw_err_reg;
    logic signed [ssw_pkg::DATA_W-1:0] measured_rate_reg;
    logic signed [ssw_pkg::DATA_W-1:0] wanted_rate_reg;
    logic                              ready_req_reg;
    logic signed [1:0]                 dir_reg;
    logic signed [1:0]                 dir_next;
    logic                              out_valid_reg;
    logic signed [1:0]                 out_dir_reg;
    logic                              advance;
    logic                              take;

    ssw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssw_law u_law (
        .cfg           (cfg),
        .yaw_err       (yaw_err_reg),
        .measured_rate (measured_rate_reg),
        .wanted_rate   (wanted_rate_reg),
        .ready_req     (ready_req_reg),
        .dir_cur       (dir_reg),
        .dir_new       (dir_next)
    );

    // move the held item into the result stage when that stage frees up
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dir_reg       <= ssw_pkg::DIR_OFF;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                dir_reg       <= dir_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            yaw_err_reg       <= yaw_err;
            measured_rate_reg <= measured_rate;
            wanted_rate_reg   <= wanted_rate;
            ready_req_reg     <= ready_req;
        end
        if (advance)
            out_dir_reg <= dir_next;
    end

    assign result_valid = out_valid_reg;
    assign wheel_dir    = out_dir_reg;

endmodule

[hw/rtl/ssw_regs.sv]
// APB-style configuration register bank.
module ssw_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssw_pkg::ADDR_W-1:0]    paddr,
    input  logic [ssw_pkg::PDATA_W-1:0]   pwdata,
    output logic [ssw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output ssw_pkg::cfg_t                 cfg
);

    ssw_pkg::cfg_t     cfg_reg;
    ssw_pkg::reg_idx_t idx;
    logic              wr_en;
    logic [ssw_pkg::LEVEL_W-1:0] wdata15;

    assign idx     = ssw_pkg::reg_idx_t'(paddr[ssw_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign wdata15 = pwdata[ssw_pkg::LEVEL_W-1:0];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_enable       <= 1'b1;
            cfg_reg.surface_gain         <= ssw_pkg::RST_SURFACE_GAIN;
            cfg_reg.surface_on_level     <= ssw_pkg::RST_SURFACE_ON;
            cfg_reg.surface_off_level    <= ssw_pkg::RST_SURFACE_OFF;
            cfg_reg.error_on_level       <= ssw_pkg::RST_ERROR_ON;
            cfg_reg.error_off_level      <= ssw_pkg::RST_ERROR_OFF;
            cfg_reg.rate_limit           <= ssw_pkg::RST_RATE_LIMIT;
            cfg_reg.rate_error_off_level <= ssw_pkg::RST_RATE_ERROR_OFF;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ssw_pkg::REG_CONTROL_ENABLE: cfg_reg.control_enable       <= pwdata[0];
                ssw_pkg::REG_SURFACE_GAIN:   cfg_reg.surface_gain         <= wdata15;
                ssw_pkg::REG_SURFACE_ON:     cfg_reg.surface_on_level     <= wdata15;
                ssw_pkg::REG_SURFACE_OFF:    cfg_reg.surface_off_level    <= wdata15;
                ssw_pkg::REG_ERROR_ON:       cfg_reg.error_on_level       <= wdata15;
                ssw_pkg::REG_ERROR_OFF:      cfg_reg.error_off_level      <= wdata15;
                ssw_pkg::REG_RATE_LIMIT:     cfg_reg.rate_limit           <= wdata15;
                ssw_pkg::REG_RATE_ERROR_OFF: cfg_reg.rate_error_off_level <= wdata15;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            ssw_pkg::REG_CONTROL_ENABLE: prdata[0] = cfg_reg.control_enable;
            ssw_pkg::REG_SURFACE_GAIN:
                prdata[ssw_pkg::LEVEL_W-1:0] = cfg_reg.surface_gain;
            ssw_pkg::REG_SURFACE_ON:
                prdata[ssw_pkg::LEVEL_W-1:0] = cfg_reg.surface_on_level;
            ssw_pkg::REG_SURFACE_OFF:
                prdata[ssw_pkg::LEVEL_W-1:0] = cfg_reg.surface_off_level;
            ssw_pkg::REG_ERROR_ON:
                prdata[ssw_pkg::LEVEL_W-1:0] = cfg_reg.error_on_level;
            ssw_pkg::REG_ERROR_OFF:
                prdata[ssw_pkg::LEVEL_W-1:0] = cfg_reg.error_off_level;
            ssw_pkg::REG_RATE_LIMIT:
                prdata[ssw_pkg::LEVEL_W-1:0] = cfg_reg.rate_limit;
            ssw_pkg::REG_RATE_ERROR_OFF:
                prdata[ssw_pkg::LEVEL_W-1:0] = cfg_reg.rate_error_off_level;
            default: prdata = '0;
        endcase
    end

endmodule

[hw/rtl/ssw_law.sv]
// Sliding surface and hysteresis switching law for one control tick.
module ssw_law (
    input  ssw_pkg::cfg_t                       cfg,
    input  logic signed [ssw_pkg::DATA_W-1:0]   yaw_err,
    input  logic signed [ssw_pkg::DATA_W-1:0]   measured_rate,
    input  logic signed [ssw_pkg::DATA_W-1:0]   wanted_rate,
    input  logic                                ready_req,
    input  logic signed [1:0]                   dir_cur,
    output logic signed [1:0]                   dir_new
);

    localparam int unsigned RE_W = ssw_pkg::DATA_W + 1;
    localparam int unsigned CW   = ssw_pkg::DATA_W + 2;
    localparam int unsigned PAD  = ssw_pkg::SURF_W - ssw_pkg::LEVEL_W - ssw_pkg::Q_FRAC;

    logic signed [RE_W-1:0]              rate_err;
    logic signed [ssw_pkg::DATA_W-1:0]   gain_s;
    logic signed [2*ssw_pkg::DATA_W-1:0] prod;
    logic signed [ssw_pkg::SURF_W-1:0]   surf;
    logic signed [ssw_pkg::SURF_W-1:0]   s_on;
    logic signed [ssw_pkg::SURF_W-1:0]   s_off;
    logic [ssw_pkg::LEVEL_W-1:0]         e_off_lvl;
    logic signed [CW-1:0]                yerr_x;
    logic signed [CW-1:0]                yr_x;
    logic signed [CW-1:0]                yre_x;
    logic signed [CW-1:0]                e_on;
    logic signed [CW-1:0]                e_off;
    logic signed [CW-1:0]                r_lim;
    logic signed [CW-1:0]                re_off;

    always_comb
    begin
        rate_err = RE_W'(wanted_rate) - RE_W'(measured_rate);
        gain_s   = signed'({1'b0, cfg.surface_gain});
        prod     = gain_s * yaw_err;
        surf     = (ssw_pkg::SURF_W'(rate_err) <<< ssw_pkg::Q_FRAC)
                   + ssw_pkg::SURF_W'(prod);
        s_on     = signed'({{PAD{1'b0}}, cfg.surface_on_level, {ssw_pkg::Q_FRAC{1'b0}}});
        s_off    = signed'({{PAD{1'b0}}, cfg.surface_off_level, {ssw_pkg::Q_FRAC{1'b0}}});

        e_off_lvl = (cfg.error_off_level < cfg.error_on_level)
                    ? cfg.error_off_level : cfg.error_on_level;
        yerr_x   = CW'(yaw_err);
        yr_x     = CW'(measured_rate);
        yre_x    = CW'(rate_err);
        e_on     = signed'(CW'(cfg.error_on_level));
        e_off    = signed'(CW'(e_off_lvl));
        r_lim    = signed'(CW'(cfg.rate_limit));
        re_off   = signed'(CW'(cfg.rate_error_off_level));
    end

    always_comb
    begin
        dir_new = dir_cur;
        if (!cfg.control_enable || !ready_req)
        begin
            dir_new = ssw_pkg::DIR_OFF;
        end
        else if (dir_cur == ssw_pkg::DIR_OFF)
        begin
            // surface has priority over the yaw error for turn-on
            priority if (surf > s_on)     dir_new = ssw_pkg::DIR_POS;
            else if (surf < -s_on)        dir_new = ssw_pkg::DIR_NEG;
            else if (yerr_x > e_on)       dir_new = ssw_pkg::DIR_POS;
            else if (yerr_x < -e_on)      dir_new = ssw_pkg::DIR_NEG;
            else                          dir_new = ssw_pkg::DIR_OFF;
        end
        else if (dir_cur == ssw_pkg::DIR_POS)
        begin
            if (surf < s_off || yre_x < re_off || yr_x > r_lim || yerr_x < -e_off)
                dir_new = ssw_pkg::DIR_OFF;
        end
        else
        begin
            if (surf > -s_off || yre_x > -re_off || yr_x < -r_lim || yerr_x > e_off)
                dir_new = ssw_pkg::DIR_OFF;
        end
    end

endmodule

[verif/sliding_surface_wheel_relay_test.sv]
// Self-checking testbench for the sliding surface wheel relay: tick stimulus, wheel command check.
`timescale 1ns / 100ps

module sliding_surface_wheel_relay_test;
    import ssw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS = 185;

    typedef struct {
        logic signed [DATA_W-1:0] yaw;
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] want;
        logic                     ready;
    } tick_t;

    // Tracks the wheel direction and queues the command expected for each tick.
    class wheel_dir_tracker;
        cfg_t                cfg;
        logic signed [1:0]   dir;
        logic signed [1:0]   dir_expected[$];
        int unsigned         errors;

        function new();
            cfg.control_enable       = 1'b1;
            cfg.surface_gain         = RST_SURFACE_GAIN;
            cfg.surface_on_level     = RST_SURFACE_ON;
            cfg.surface_off_level    = RST_SURFACE_OFF;
            cfg.error_on_level       = RST_ERROR_ON;
            cfg.error_off_level      = RST_ERROR_OFF;
            cfg.rate_limit           = RST_RATE_LIMIT;
            cfg.rate_error_off_level = RST_RATE_ERROR_OFF;
            dir    = DIR_OFF;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] v);
            case (idx)
                REG_CONTROL_ENABLE: cfg.control_enable       = v[0];
                REG_SURFACE_GAIN:   cfg.surface_gain         = v[LEVEL_W-1:0];
                REG_SURFACE_ON:     cfg.surface_on_level     = v[LEVEL_W-1:0];
                REG_SURFACE_OFF:    cfg.surface_off_level    = v[LEVEL_W-1:0];
                REG_ERROR_ON:       cfg.error_on_level       = v[LEVEL_W-1:0];
                REG_ERROR_OFF:      cfg.error_off_level      = v[LEVEL_W-1:0];
                REG_RATE_LIMIT:     cfg.rate_limit           = v[LEVEL_W-1:0];
                REG_RATE_ERROR_OFF: cfg.rate_error_off_level = v[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(tick_t t);
            longint yaw, meas, rerr, surf, s_on, s_off, e_on, e_off, r_lim, re_off;
            yaw    = longint'(t.yaw);
            meas   = longint'(t.meas);
            rerr   = longint'(t.want) - meas;
            surf   = (rerr <<< Q_FRAC) + longint'(cfg.surface_gain) * yaw;
            s_on   = longint'(cfg.surface_on_level) <<< Q_FRAC;
            s_off  = longint'(cfg.surface_off_level) <<< Q_FRAC;
            e_on   = longint'(cfg.error_on_level);
            // the reversed-error level never exceeds the on level
            e_off  = (cfg.error_off_level < cfg.error_on_level) ?
                     longint'(cfg.error_off_level) : e_on;
            r_lim  = longint'(cfg.rate_limit);
            re_off = longint'(cfg.rate_error_off_level);

            if (!cfg.control_enable || !t.ready) begin
                dir = DIR_OFF;
            end
            else if (dir == DIR_OFF) begin
                if (surf > s_on)
                    dir = DIR_POS;
                else if (surf < -s_on)
                    dir = DIR_NEG;
                else if (yaw > e_on)
                    dir = DIR_POS;
                else if (yaw < -e_on)
                    dir = DIR_NEG;
            end
            else if (dir == DIR_POS) begin
                if (surf < s_off || rerr < re_off || meas > r_lim || yaw < -e_off)
                    dir = DIR_OFF;
            end
            else begin
                if (surf > -s_off || rerr > -re_off || meas < -r_lim || yaw > e_off)
                    dir = DIR_OFF;
            end
            dir_expected.push_back(dir);
        endfunction

        function void check_dir(logic signed [1:0] got);
            logic signed [1:0] want_dir;
            if (dir_expected.size() == 0) begin
                $error("wheel_dir: expected nothing, got %0d", got);
                errors++;
                return;
            end
            want_dir = dir_expected.pop_front();
            if (got !== want_dir) begin
                $error("wheel_dir: expected %0d, got %0d", want_dir, got);
                errors++;
            end
        endfunction
    endclass

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [ADDR_W-1:0]         paddr         = '0;
    logic [PDATA_W-1:0]        pwdata        = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      item_valid    = 1'b0;
    logic                      item_stall;
    logic signed [DATA_W-1:0]  yaw_err       = '0;
    logic signed [DATA_W-1:0]  measured_rate = '0;
    logic signed [DATA_W-1:0]  wanted_rate   = '0;
    logic                      ready_req     = 1'b0;
    logic                      result_valid;
    logic                      result_stall  = 1'b0;
    logic signed [1:0]         wheel_dir;

    wheel_dir_tracker sb = new();

    int unsigned cycle_count = 0;
    int unsigned rx_wait     = 0;
    int unsigned hold_left   = 0;
    bit          rx_quiet    = 1'b0;
    bit          tx_quiet    = 1'b0;
    bit          tx_force    = 1'b0;

    sliding_surface_wheel_relay u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .yaw_err       (yaw_err),
        .measured_rate (measured_rate),
        .wanted_rate   (wanted_rate),
        .ready_req     (ready_req),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .wheel_dir     (wheel_dir)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: a long hold-off takes precedence over the per-item wait.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_dir(wheel_dir);
            if ($urandom_range(0, 49) == 0)
                rx_quiet = !rx_quiet;
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
        end
    end

    function automatic logic signed [DATA_W-1:0] sat16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return DATA_W'(v);
    endfunction

    function automatic tick_t mk_tick(int y, int m, int w, bit r);
        tick_t t;
        t.yaw   = sat16(y);
        t.meas  = sat16(m);
        t.want  = sat16(w);
        t.ready = r;
        return t;
    endfunction

    // Value clustered around +/-lvl, with full-range and extreme values mixed in.
    function automatic logic signed [DATA_W-1:0] level_probe(int lvl);
        longint v;
        case ($urandom_range(0, 9))
            0, 1, 2:    v = longint'($urandom_range(0, 65535)) - 32768;
            3, 4, 5, 6: v = longint'($urandom_range(0, 2 * lvl + 64)) - (lvl + 32);
            7, 8:
            begin
                v = lvl + longint'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:    v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        return sat16(v);
    endfunction

    function automatic tick_t draw_tick();
        tick_t  t;
        longint tgt, rerr;
        t.yaw  = level_probe(sb.cfg.error_on_level);
        t.meas = level_probe(sb.cfg.rate_limit);
        case ($urandom_range(0, 3))
            0:
            begin
                t.yaw  = DATA_W'($urandom);
                t.meas = DATA_W'($urandom);
                t.want = DATA_W'($urandom);
            end
            1: t.want = level_probe(sb.cfg.rate_limit);
            2: t.want = sat16(longint'(t.meas) + level_probe(sb.cfg.rate_error_off_level));
            default:
            begin
                // aim the surface at one of its levels
                tgt = $urandom_range(0, 1) ? sb.cfg.surface_on_level : sb.cfg.surface_off_level;
                tgt = tgt + longint'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1))
                    tgt = -tgt;
                rerr = ((tgt <<< Q_FRAC) - longint'(sb.cfg.surface_gain) * longint'(t.yaw))
                       / (longint'(1) <<< Q_FRAC);
                rerr = rerr + longint'($urandom_range(0, 2)) - 1;
                t.want = sat16(longint'(t.meas) + rerr);
            end
        endcase
        t.ready = ($urandom_range(0, 9) != 0);
        return t;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_tick(tick_t t);
        int unsigned gap;
        gap = (tx_quiet || tx_force) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid    <= 1'b1;
        yaw_err       <= t.yaw;
        measured_rate <= t.meas;
        wanted_rate   <= t.want;
        ready_req     <= t.ready;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_tick(t);
        @(negedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.dir_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write every register; junk in the unused upper bits must be dropped.
    task automatic apply_cfg(cfg_t c, bit junk);
        logic [PDATA_W-1:0] hi;
        hi = junk ? ($urandom & 32'hFFFF_8000) : '0;
        reg_write(REG_CONTROL_ENABLE, hi | PDATA_W'(c.control_enable));
        reg_write(REG_SURFACE_GAIN,   hi | PDATA_W'(c.surface_gain));
        reg_write(REG_SURFACE_ON,     hi | PDATA_W'(c.surface_on_level));
        reg_write(REG_SURFACE_OFF,    hi | PDATA_W'(c.surface_off_level));
        reg_write(REG_ERROR_ON,       hi | PDATA_W'(c.error_on_level));
        reg_write(REG_ERROR_OFF,      hi | PDATA_W'(c.error_off_level));
        reg_write(REG_RATE_LIMIT,     hi | PDATA_W'(c.rate_limit));
        reg_write(REG_RATE_ERROR_OFF, hi | PDATA_W'(c.rate_error_off_level));
    endtask

    function automatic cfg_t pick_cfg(int kind);
        cfg_t c;
        int unsigned top;
        top = (kind == 4) ? 4095 : 32767;
        c.control_enable       = (kind != 2);
        c.surface_gain         = LEVEL_W'($urandom_range(0, (kind == 4) ? 8191 : 32767));
        c.surface_on_level     = LEVEL_W'($urandom_range(0, top));
        c.surface_off_level    = LEVEL_W'($urandom_range(0, top));
        c.error_on_level       = LEVEL_W'($urandom_range(0, top));
        c.error_off_level      = LEVEL_W'($urandom_range(0, top));
        c.rate_limit           = LEVEL_W'($urandom_range(0, top));
        c.rate_error_off_level = LEVEL_W'($urandom_range(0, top));
        case (kind)
            0:
            begin
                c = '0;
                c.control_enable = 1'b1;
                c.surface_gain   = '1;
            end
            1:
            begin
                c = '1;
                c.surface_gain = '0;
            end
            5:
            begin
                c.control_enable       = 1'b1;
                c.surface_gain         = RST_SURFACE_GAIN;
                c.surface_on_level     = RST_SURFACE_ON;
                c.surface_off_level    = RST_SURFACE_OFF;
                c.error_on_level       = RST_ERROR_ON;
                c.error_off_level      = RST_ERROR_OFF;
                c.rate_limit           = RST_RATE_LIMIT;
                c.rate_error_off_level = RST_RATE_ERROR_OFF;
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic run_random(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            send_tick(draw_tick());
        end
    endtask

    initial
    begin
        int kinds[8];
        kinds = '{0, 1, 2, 3, 4, 5, 4, 3};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: on/off paths, strict boundaries, field extremes
        send_tick(mk_tick(32767, -32768, 32767, 1'b0));
        send_tick(mk_tick(0, 0, 0, 1'b1));
        send_tick(mk_tick(0, 0, 82, 1'b1));
        send_tick(mk_tick(0, 0, 83, 1'b1));
        send_tick(mk_tick(0, 0, 83, 1'b1));
        send_tick(mk_tick(0, 1435, 1600, 1'b1));
        send_tick(mk_tick(0, 83, 0, 1'b1));
        send_tick(mk_tick(0, -1435, -1600, 1'b1));
        send_tick(mk_tick(1844, 1475, 0, 1'b1));
        send_tick(mk_tick(-820, 0, 1000, 1'b1));
        send_tick(mk_tick(-1844, -1475, 0, 1'b1));
        send_tick(mk_tick(820, 0, -1000, 1'b1));
        send_tick(mk_tick(0, 0, 100, 1'b1));
        send_tick(mk_tick(1000, 0, 19, 1'b1));
        send_tick(mk_tick(0, 0, -100, 1'b1));
        send_tick(mk_tick(-1000, 0, -19, 1'b1));
        send_tick(mk_tick(0, 0, 100, 1'b1));
        send_tick(mk_tick(-5, 0, 20, 1'b1));
        send_tick(mk_tick(0, 0, 100, 1'b1));
        send_tick(mk_tick(0, 0, 100, 1'b0));
        send_tick(mk_tick(-32768, 32767, -32768, 1'b1));
        send_tick(mk_tick(32767, -32768, 32767, 1'b1));
        send_tick(mk_tick(-32768, -32768, -32768, 1'b1));
        run_random(150);

        foreach (kinds[k])
        begin
            wait_drained();
            apply_cfg(pick_cfg(kinds[k]), k >= 3);
            if (kinds[k] == 5)
            begin
                // hold the result side off while items keep coming, so the input backs up
                hold_left = 150;
                tx_force  = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_tick(draw_tick());
                tx_force = 1'b0;
                run_random(PHASE_ITEMS - 40);
            end
            else
                run_random(PHASE_ITEMS);
        end

        wait_drained();
        if (sb.errors == 0 && sb.dir_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
